// ----- design/hbs_pkg.sv -----
// Shared types and constants for the HTTP header/body splitter.
`default_nettype none
package hbs_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  // One release command: held boundary bytes first, then optionally the data byte.
  typedef struct packed {
    logic [1:0] held_cnt;
    logic       has_byte;
    logic       body;
    logic [7:0] data;
  } cmd_t;

  // Held boundary bytes in order: CR, LF, CR.
  function automatic logic [7:0] held_byte(input logic [1:0] pos);
    logic [7:0] b;
    b = (pos == 2'd1) ? CH_LF : CH_CR;
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- design/hbs_front.sv -----
// Front end: boundary matcher that turns each accepted input byte into a release command, if any.
`default_nettype none
module hbs_front import hbs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_of_response,
  input  wire logic       split_enable,
  output logic            cmd_push,
  output cmd_t            cmd
);

  logic [1:0] match_progress, match_progress_next;
  logic       in_body, in_body_next;
  logic [1:0] mp_cur;
  logic       ib_cur;
  logic       is_cr, is_lf;

  assign is_cr = (data_byte == CH_CR);
  assign is_lf = (data_byte == CH_LF);

  always_comb begin
    mp_cur = start_of_response ? 2'd0 : match_progress;
    ib_cur = start_of_response ? 1'b0 : in_body;
    match_progress_next = mp_cur;
    in_body_next        = ib_cur;
    cmd.held_cnt = 2'd0;
    cmd.has_byte = 1'b0;
    cmd.body     = 1'b0;
    cmd.data     = data_byte;
    if (!split_enable) begin
      cmd.held_cnt        = mp_cur;
      cmd.has_byte        = 1'b1;
      match_progress_next = 2'd0;
    end else if (ib_cur) begin
      cmd.has_byte = 1'b1;
      cmd.body     = 1'b1;
    end else begin
      unique case (mp_cur)
        2'd0: begin
          if (is_cr) match_progress_next = 2'd1;
          else cmd.has_byte = 1'b1;
        end
        2'd1: begin
          if (is_lf) begin
            match_progress_next = 2'd2;
          end else if (is_cr) begin
            cmd.held_cnt = 2'd1;
          end else begin
            cmd.held_cnt        = 2'd1;
            cmd.has_byte        = 1'b1;
            match_progress_next = 2'd0;
          end
        end
        2'd2: begin
          if (is_cr) begin
            match_progress_next = 2'd3;
          end else begin
            cmd.held_cnt        = 2'd2;
            cmd.has_byte        = 1'b1;
            match_progress_next = 2'd0;
          end
        end
        default: begin
          if (is_lf) begin
            match_progress_next = 2'd0;
            in_body_next        = 1'b1;
          end else if (is_cr) begin
            cmd.held_cnt        = 2'd3;
            match_progress_next = 2'd1;
          end else begin
            cmd.held_cnt        = 2'd3;
            cmd.has_byte        = 1'b1;
            match_progress_next = 2'd0;
          end
        end
      endcase
    end
  end

  // Nothing to release -> no command.
  assign cmd_push = accept && (cmd.has_byte || (cmd.held_cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      match_progress <= 2'd0;
      in_body        <= 1'b0;
    end else if (accept) begin
      match_progress <= match_progress_next;
      in_body        <= in_body_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/hbs_cmd_fifo.sv -----
// Small command queue between the matcher and the release sequencer.
`default_nettype none
module hbs_cmd_fifo import hbs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      wr_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head
);

  cmd_t              entries [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr, rd_ptr;
  logic [CMD_CW-1:0] count;
  logic              do_wr, do_rd;

  assign full       = (count == CMD_CW'(CMD_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_wr      = push && !full;
  assign do_rd      = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == CMD_AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + CMD_AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == CMD_AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + CMD_AW'(1);
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + CMD_CW'(1);
        2'b01:   count <= count - CMD_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/hbs_back.sv -----
// Back end: expands each command into bytes of an output register, one per cycle unless pop stalls.
`default_nettype none
module hbs_back import hbs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  cmd_t            head,
  output logic            head_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            to_body,
  output logic            last_of_run
);

  logic [1:0] pos;
  logic       out_valid;
  logic       advance;
  logic       emit_held;
  logic       emit_last;

  assign advance   = head_valid && (!out_valid || pop);
  assign emit_held = (pos < head.held_cnt);
  assign emit_last = head.has_byte ? (pos == head.held_cnt)
                                   : (pos == head.held_cnt - 2'd1);
  assign head_pop  = advance && emit_last;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        pos       <= emit_last ? 2'd0 : pos + 2'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= emit_held ? held_byte(pos) : head.data;
      to_body     <= emit_held ? 1'b0 : head.body;
      last_of_run <= emit_last;
    end
  end

endmodule
`default_nettype wire

// ----- design/http_header_body_splitter_core.sv -----
// Top level of the HTTP header/body splitter: matcher, command queue, release sequencer.
//
//   channel   direction  handshake         fields
//   -------   ---------  ----------------  ----------------------------------------
//   input     in         push / full       data_byte, start_of_response, end_of_chunk
//   result    out        empty / pop       out_byte, to_body, last_of_run
//   config    in         cfg_write         cfg_data (split_enable)
//
// The matcher classifies one input request per cycle while full is low and writes any
// release command it produces into a four-entry queue. The sequencer emits one result per
// cycle while pop keeps up, so an input causing k results holds it for k results in turn;
// the queue absorbs bursts of up to four. Results pass through the queue and the output register.
// full rises only when the queue holds four commands; a waiting result stays on the
// result ports while pop is low.
// Reset (rst, synchronous) empties the queue and output, clears matcher state and sets
// split_enable to 1. end_of_chunk has no effect on matching or results.
`default_nettype none
module http_header_body_splitter_core import hbs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_of_response,
  input  wire logic       end_of_chunk,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            to_body,
  output logic            last_of_run,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data
);

  logic split_enable;
  logic accept;
  logic cmd_push;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic head_pop;
  logic chunk_mark;

  // Chunk marks do not steer anything; kept for the stream interface only.
  assign chunk_mark = end_of_chunk;
  assign accept     = push && !full && (chunk_mark || !chunk_mark);

  always_ff @(posedge clk) begin
    if (rst) begin
      split_enable <= 1'b1;
    end else if (cfg_write) begin
      split_enable <= cfg_data;
    end
  end

  hbs_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .data_byte         (data_byte),
    .start_of_response (start_of_response),
    .split_enable      (split_enable),
    .cmd_push          (cmd_push),
    .cmd               (cmd)
  );

  hbs_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .wr_cmd     (cmd),
    .full       (full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hbs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .head_pop    (head_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .to_body     (to_body),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

// ----- dv/tb_http_header_body_splitter_core.sv -----
// Self-checking testbench for the HTTP header/body splitter core.
`default_nettype none
module tb_http_header_body_splitter_core;
  import hbs_pkg::*;

  localparam int ITEM_TARGET  = 370;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 80;   // receiver hold-off during the backpressure test
  localparam int SETTLE_TICKS = 12;   // covers the pipeline after the last result
  localparam int DRAIN_LIMIT  = 4000;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       start_of_response;
  logic       end_of_chunk;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       to_body;
  logic       last_of_run;
  logic       cfg_write;
  logic       cfg_data;

  http_header_body_splitter_core uut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .data_byte         (data_byte),
    .start_of_response (start_of_response),
    .end_of_chunk      (end_of_chunk),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .to_body           (to_body),
    .last_of_run       (last_of_run),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data)
  );

  // One released byte as the output side should show it.
  typedef struct {
    logic [7:0] data;
    logic       body;
    logic       last;
  } release_t;

  release_t pending_releases[$];

  // Shadow of the splitter: held boundary bytes, body flag, split setting.
  logic [1:0] hold_cnt;
  logic       past_boundary;
  logic       split_on;

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int full_cycles  = 0;
  int cfg_writes   = 0;
  int cycle_cnt    = 0;
  int body_results = 0;

  bit no_idle  = 0;  // both sides run flat out
  bit hold_req = 0;  // asks the result side for one long hold-off
  bit next_sor = 0;  // start_of_response for the next request

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected releases for one accepted request. Boundary bytes held so far are
  // always CR, LF, CR in that order; the input byte follows them if it is not
  // kept back itself.
  function automatic void route_byte(input logic [7:0] c, input logic sor);
    int       flushed;
    logic     pass_byte;
    logic     dest_body;
    release_t r;
    flushed   = 0;
    pass_byte = 1'b0;
    dest_body = 1'b0;
    if (sor) begin
      hold_cnt      = 2'd0;
      past_boundary = 1'b0;
    end
    if (!split_on) begin
      // pass-through: flush anything held, body flag only parked
      flushed   = int'(hold_cnt);
      hold_cnt  = 2'd0;
      pass_byte = 1'b1;
    end else if (past_boundary) begin
      pass_byte = 1'b1;
      dest_body = 1'b1;
    end else begin
      case (hold_cnt)
        2'd0: begin
          if (c == CH_CR) hold_cnt = 2'd1;
          else pass_byte = 1'b1;
        end
        2'd1: begin
          if (c == CH_LF) begin
            hold_cnt = 2'd2;
          end else if (c == CH_CR) begin
            flushed = 1;             // old CR out, new CR restarts the match
          end else begin
            flushed   = 1;
            pass_byte = 1'b1;
            hold_cnt  = 2'd0;
          end
        end
        2'd2: begin
          if (c == CH_CR) begin
            hold_cnt = 2'd3;
          end else begin
            flushed   = 2;
            pass_byte = 1'b1;
            hold_cnt  = 2'd0;
          end
        end
        default: begin
          if (c == CH_LF) begin
            hold_cnt      = 2'd0;    // boundary found, nothing released
            past_boundary = 1'b1;
          end else if (c == CH_CR) begin
            flushed  = 3;
            hold_cnt = 2'd1;
          end else begin
            flushed   = 3;
            pass_byte = 1'b1;
            hold_cnt  = 2'd0;
          end
        end
      endcase
    end
    for (int i = 0; i < flushed; i++) begin
      r.data = (i == 1) ? CH_LF : CH_CR;
      r.body = 1'b0;
      r.last = (i == flushed - 1) && !pass_byte;
      pending_releases.push_back(r);
    end
    if (pass_byte) begin
      r.data = c;
      r.body = dest_body;
      r.last = 1'b1;
      pending_releases.push_back(r);
    end
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Drive one request at the falling edge and hold it until a rising edge with
  // full low takes it. push stays high afterwards; the next call or a drain
  // updates it at the very next falling edge, so nothing is taken twice.
  task automatic send_req(input logic [7:0] d, input logic eoc);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push              = 1'b1;
    data_byte         = d;
    start_of_response = next_sor;
    end_of_chunk      = eoc;
    do @(posedge clk); while (full);
    route_byte(d, next_sor);
    next_sor = 1'b0;
    items_sent++;
  endtask

  // Stop pushing, let every expected result out, then give the matcher time to
  // finish requests that release nothing.
  task automatic wait_drain();
    int n;
    @(negedge clk);
    push = 1'b0;
    n = 0;
    while (pending_releases.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_releases.size() != 0) begin
      $display("%0t ERROR: %0d expected results never arrived, next expected %h body %0b",
               $time, pending_releases.size(), pending_releases[0].data,
               pending_releases[0].body);
      errors++;
      pending_releases.delete();
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_split(input logic en);
    wait_drain();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = en;
    @(negedge clk);
    cfg_write = 1'b0;
    split_on  = en;
    cfg_writes++;
  endtask

  task automatic send_boundary();
    send_req(CH_CR, 1'b0);
    send_req(CH_LF, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_LF, 1'b0);
  endtask

  // Header paths: byte extremes, every partial-match failure, the boundary,
  // body bytes that look like boundary bytes, and a start that drops held bytes.
  task automatic test_directed_header_paths();
    next_sor = 1'b1;
    send_req(8'h48, 1'b0);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b1);
    send_req(CH_CR, 1'b0);
    send_req(CH_CR, 1'b0);         // CR after CR: one CR out, one kept
    send_req(8'h41, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_LF, 1'b0);
    send_req(8'h78, 1'b0);         // CR LF broken
    send_req(CH_CR, 1'b0);
    send_req(CH_LF, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_CR, 1'b0);         // CR LF CR broken by CR
    send_req(CH_LF, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(8'h7A, 1'b1);         // CR LF CR broken by text
    send_boundary();               // boundary itself releases nothing
    send_req(CH_CR, 1'b0);
    send_req(8'hFF, 1'b1);
    send_req(CH_LF, 1'b0);
    send_req(8'h00, 1'b0);
    next_sor = 1'b1;
    send_req(CH_CR, 1'b0);
    send_req(CH_LF, 1'b0);
    next_sor = 1'b1;               // held CR LF dropped silently
    send_req(8'h62, 1'b0);
    wait_drain();
  endtask

  // Pass-through mode: held bytes flushed, boundary ignored, body flag parked.
  task automatic test_split_disable();
    next_sor = 1'b1;
    send_req(8'h71, 1'b0);
    send_req(CH_CR, 1'b0);
    send_req(CH_LF, 1'b0);         // stream pauses with CR LF held
    set_split(1'b0);
    send_req(8'h72, 1'b0);         // held CR LF come out ahead of it
    send_boundary();
    set_split(1'b1);
    next_sor = 1'b1;
    send_boundary();
    send_req(8'h62, 1'b1);
    set_split(1'b0);
    send_req(8'h68, 1'b0);
    set_split(1'b1);
    send_req(8'h63, 1'b0);         // body flag survived the disabled stretch
    wait_drain();
  endtask

  // Result side holds off for a long stretch while four-byte releases keep
  // coming back to back, so the command queue fills and full stalls the input.
  task automatic test_full_backpressure();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    next_sor = 1'b1;
    repeat (6) begin
      send_req(CH_CR, 1'b0);
      send_req(CH_LF, 1'b0);
      send_req(CH_CR, 1'b0);
      send_req(8'h2D, 1'b0);
    end
    wait_drain();
    no_idle = 1'b0;
  endtask

  // A well-formed response with random content: header lines with the odd
  // near miss, usually a boundary, then a random body.
  task automatic send_response();
    int lines;
    int len;
    int r;
    next_sor = 1'b1;
    lines = $urandom_range(0, 3);
    repeat (lines) begin
      len = $urandom_range(0, 6);
      repeat (len) send_req(8'($urandom_range(8'h20, 8'h7E)), 1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      send_req(CH_CR, 1'b0);
      if (r < 70) begin
        send_req(CH_LF, 1'($urandom_range(0, 1)));
      end else if (r < 80) begin
        send_req(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end else if (r < 90) begin
        send_req(CH_LF, 1'b0);
        send_req(CH_CR, 1'b0);
        send_req(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end else begin
        send_req(CH_CR, 1'b0);
        send_req(CH_LF, 1'b0);
      end
    end
    if ($urandom_range(0, 9) != 0) send_boundary();
    len = $urandom_range(0, 12);
    repeat (len) send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Noise: arbitrary bytes, CR and LF often, starts at random.
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      next_sor = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
        0:       send_req(CH_CR, 1'($urandom_range(0, 1)));
        1:       send_req(CH_LF, 1'($urandom_range(0, 1)));
        default: send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int phase_start;
    phase       = 0;
    phase_start = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 80) send_response();
      else send_noise();
      if (items_sent - phase_start >= 70) begin
        phase++;
        set_split(phase % 3 != 1);
        no_idle     = (phase % 4 == 2);
        phase_start = items_sent;
      end
    end
    wait_drain();
    no_idle = 1'b0;
  endtask

  // Result side: pop at the falling edge with random hold-offs; a long one
  // when the backpressure test asks for it.
  initial begin : result_side
    int hold;
    int r;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = LONG_HOLD;
      end
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else if (no_idle) begin
        pop = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          pop  = 1'b0;
          hold = $urandom_range(0, 2);
        end else if (r < 24) begin
          pop  = 1'b0;
          hold = $urandom_range(6, 30);
        end else begin
          pop = 1'b1;
        end
      end
    end
  end

  // Every popped result is checked against the oldest expectation.
  always @(posedge clk) begin
    release_t want;
    if (!rst && push && full) full_cycles++;
    if (!rst && pop && !empty) begin
      if (pending_releases.size() == 0) begin
        $display("%0t ERROR: unexpected result, expected none, got byte %h body %0b last %0b",
                 $time, out_byte, to_body, last_of_run);
        errors++;
      end else begin
        want = pending_releases.pop_front();
        results_seen++;
        if (want.body) body_results++;
        if (out_byte !== want.data) begin
          $display("%0t ERROR: out_byte expected %h got %h", $time, want.data, out_byte);
          errors++;
        end
        if (to_body !== want.body) begin
          $display("%0t ERROR: to_body expected %0b got %0b", $time, want.body, to_body);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $display("%0t ERROR: last_of_run expected %0b got %0b", $time, want.last,
                   last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t ERROR: cycle limit reached, %0d results outstanding", $time,
               pending_releases.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    push              = 1'b0;
    data_byte         = 8'h00;
    start_of_response = 1'b0;
    end_of_chunk      = 1'b0;
    cfg_write         = 1'b0;
    cfg_data          = 1'b0;
    hold_cnt          = 2'd0;
    past_boundary     = 1'b0;
    split_on          = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_header_paths();
    test_split_disable();
    test_full_backpressure();
    test_random_traffic();

    $display("Covered %0d requests, %0d results checked (%0d to body), %0d split writes",
             items_sent, results_seen, body_results, cfg_writes);
    $display("Input stalled by a full queue for %0d cycles, %0d mismatches",
             full_cycles, errors);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
